// ----- rtl/tovc_pkg.sv -----
`timescale 1ns / 1ps

package tovc_pkg;

  localparam int PC_W = 4;
  localparam int STEP_W = 5;

  localparam logic [31:0] COUNTER_SPAN = 32'h0001_0000;
  localparam logic [31:0] FREQ_RESET = 32'd67108864;
  localparam logic [29:0] NS_PER_S = 30'd1000000000;

  // two quotient bits per divider cycle
  localparam logic [STEP_W-1:0] DIV_LAST_LONG = 5'd31;
  localparam logic [STEP_W-1:0] DIV_LAST_SHORT = 5'd22;
  localparam int DIV_SHORT_SHIFT = 18;

  typedef enum logic {
    REG_ENABLED   = 1'b0,
    REG_FREQUENCY = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    SQ_NEXT   = 4'b0001,
    SQ_WAIT   = 4'b0010,
    SQ_BRANCH = 4'b0100,
    SQ_END    = 4'b1000
  } seq_op_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MUL_REM,
    OP_MUL_VAL,
    OP_SHL10,
    OP_SUB4,
    OP_SUB3
  } alu_op_t;

  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_SEC,
    CAP_NS1,
    CAP_NS2,
    CAP_MS
  } cap_t;

  typedef struct packed {
    seq_op_t           seq;
    logic [PC_W-1:0]   target;
    alu_op_t           alu;
    logic              div_go;
    logic              div_long;
    logic              dvd_acc;
    logic              dvs_freq;
    cap_t              cap;
    logic              zero;
  } ctrl_t;

  typedef struct packed {
    logic div_busy;
    logic absent;
  } stat_t;

  localparam logic [PC_W-1:0] PC_ZERO = 4'd15;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      4'd0:  w = '{SQ_BRANCH, PC_ZERO, OP_NONE,    1'b1, 1'b1, 1'b0, 1'b0, CAP_NONE, 1'b0};
      4'd1:  w = '{SQ_WAIT,   4'd0,    OP_NONE,    1'b0, 1'b0, 1'b0, 1'b0, CAP_SEC,  1'b0};
      4'd2:  w = '{SQ_NEXT,   4'd0,    OP_MUL_REM, 1'b0, 1'b0, 1'b0, 1'b0, CAP_NONE, 1'b0};
      4'd3:  w = '{SQ_NEXT,   4'd0,    OP_NONE,    1'b1, 1'b0, 1'b1, 1'b0, CAP_NONE, 1'b0};
      4'd4:  w = '{SQ_WAIT,   4'd0,    OP_NONE,    1'b0, 1'b0, 1'b0, 1'b0, CAP_NS1,  1'b0};
      4'd5:  w = '{SQ_NEXT,   4'd0,    OP_MUL_VAL, 1'b0, 1'b0, 1'b0, 1'b0, CAP_NONE, 1'b0};
      4'd6:  w = '{SQ_NEXT,   4'd0,    OP_NONE,    1'b1, 1'b0, 1'b1, 1'b1, CAP_NONE, 1'b0};
      4'd7:  w = '{SQ_WAIT,   4'd0,    OP_NONE,    1'b0, 1'b0, 1'b0, 1'b0, CAP_NS2,  1'b0};
      4'd8:  w = '{SQ_NEXT,   4'd0,    OP_SHL10,   1'b0, 1'b0, 1'b0, 1'b0, CAP_NONE, 1'b0};
      4'd9:  w = '{SQ_NEXT,   4'd0,    OP_SUB4,    1'b0, 1'b0, 1'b0, 1'b0, CAP_NONE, 1'b0};
      4'd10: w = '{SQ_NEXT,   4'd0,    OP_SUB3,    1'b0, 1'b0, 1'b0, 1'b0, CAP_NONE, 1'b0};
      4'd11: w = '{SQ_NEXT,   4'd0,    OP_NONE,    1'b1, 1'b1, 1'b1, 1'b0, CAP_NONE, 1'b0};
      4'd12: w = '{SQ_WAIT,   4'd0,    OP_NONE,    1'b0, 1'b0, 1'b0, 1'b0, CAP_MS,   1'b0};
      4'd13: w = '{SQ_END,    4'd0,    OP_NONE,    1'b0, 1'b0, 1'b0, 1'b0, CAP_NONE, 1'b0};
      4'd14: w = '{SQ_END,    4'd0,    OP_NONE,    1'b0, 1'b0, 1'b0, 1'b0, CAP_NONE, 1'b1};
      4'd15: w = '{SQ_END,    4'd0,    OP_NONE,    1'b0, 1'b0, 1'b0, 1'b0, CAP_NONE, 1'b1};
      default: w = '{SQ_END,  4'd0,    OP_NONE,    1'b0, 1'b0, 1'b0, 1'b0, CAP_NONE, 1'b1};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/tovc_div.sv -----
`timescale 1ns / 1ps

module tovc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic        long_div,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quot,
  output logic [31:0] rem
);

  logic                             run_r, run_nxt;
  logic [tovc_pkg::STEP_W-1:0]      left_r, left_nxt;
  logic [63:0]                      quot_r, quot_nxt;
  logic [31:0]                      rem_r, rem_nxt;
  logic [31:0]                      dvs_r, dvs_nxt;

  always_comb begin
    logic [32:0] t;
    logic [31:0] r;
    logic [63:0] q;
    run_nxt  = run_r;
    left_nxt = left_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    r = rem_r;
    q = quot_r;
    for (int k = 0; k < 2; k++) begin
      t = {r, q[63]};
      q = {q[62:0], 1'b0};
      if (t >= {1'b0, dvs_r}) begin
        t = t - {1'b0, dvs_r};
        q[0] = 1'b1;
      end
      r = t[31:0];
    end
    if (go) begin
      run_nxt  = 1'b1;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      if (long_div) begin
        left_nxt = tovc_pkg::DIV_LAST_LONG;
        quot_nxt = dividend;
      end else begin
        left_nxt = tovc_pkg::DIV_LAST_SHORT;
        quot_nxt = dividend << tovc_pkg::DIV_SHORT_SHIFT;
      end
    end else if (run_r) begin
      quot_nxt = q;
      rem_nxt  = r;
      left_nxt = left_r - 1'b1;
      if (left_r == '0) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      left_r <= '0;
    end else begin
      run_r  <= run_nxt;
      left_r <= left_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign busy = run_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/tovc_seq.sv -----
`timescale 1ns / 1ps

module tovc_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            launch,
  input  tovc_pkg::stat_t stat,
  output tovc_pkg::ctrl_t ctrl,
  output logic            step_en,
  output logic            busy,
  output logic            out_strobe
);

  logic [tovc_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                      busy_r, busy_nxt;
  logic                      strobe_r, strobe_nxt;

  assign ctrl = tovc_pkg::ucode(pc_r);

  always_comb begin
    pc_nxt     = pc_r;
    busy_nxt   = busy_r;
    strobe_nxt = 1'b0;
    if (launch) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (busy_r) begin
      unique case (ctrl.seq)
        tovc_pkg::SQ_NEXT: pc_nxt = pc_r + 1'b1;
        tovc_pkg::SQ_WAIT: begin
          if (!stat.div_busy) begin
            pc_nxt = pc_r + 1'b1;
          end
        end
        tovc_pkg::SQ_BRANCH: pc_nxt = stat.absent ? ctrl.target : pc_r + 1'b1;
        tovc_pkg::SQ_END: begin
          busy_nxt   = 1'b0;
          strobe_nxt = 1'b1;
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      pc_r     <= pc_nxt;
      busy_r   <= busy_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign step_en    = busy_r;
  assign busy       = busy_r;
  assign out_strobe = strobe_r;

endmodule

// ----- rtl/tovc_dp.sv -----
`timescale 1ns / 1ps

module tovc_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  logic [63:0]     ld_count,
  input  logic [15:0]     ld_value,
  input  logic            ld_active,
  input  logic            ld_absent,
  input  logic [31:0]     ld_freq,
  input  tovc_pkg::ctrl_t ctrl,
  input  logic            step_en,
  output tovc_pkg::stat_t stat,
  output logic            out_clock_active,
  output logic [63:0]     out_milliseconds,
  output logic [63:0]     out_seconds,
  output logic [30:0]     out_nanoseconds
);

  logic [63:0] cnt_r;
  logic [15:0] val_r;
  logic        act_r;
  logic        absent_r;
  logic [31:0] frq_r;
  logic [15:0] per_r;
  logic [63:0] acc_r, acc_nxt;
  logic [15:0] rem_r;
  logic [63:0] sec_r;
  logic [63:0] ms_r;
  logic [30:0] ns_r;

  logic        div_busy;
  logic [63:0] div_quot;
  logic [31:0] div_rem;
  logic [15:0] mul_in;
  logic [45:0] prod;
  logic        advance;
  logic        emit;

  tovc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (step_en && ctrl.div_go),
    .long_div (ctrl.div_long),
    .dividend (ctrl.dvd_acc ? acc_r : cnt_r),
    .divisor  (ctrl.dvs_freq ? frq_r : {16'b0, per_r}),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign stat.div_busy = div_busy;
  assign stat.absent   = absent_r;

  assign mul_in  = (ctrl.alu == tovc_pkg::OP_MUL_REM) ? rem_r : val_r;
  assign prod    = 46'(mul_in) * 46'(tovc_pkg::NS_PER_S);
  assign advance = step_en && !div_busy;
  assign emit    = step_en && (ctrl.seq == tovc_pkg::SQ_END);

  always_comb begin
    acc_nxt = acc_r;
    if (step_en) begin
      unique case (ctrl.alu)
        tovc_pkg::OP_NONE:    acc_nxt = acc_r;
        tovc_pkg::OP_MUL_REM: acc_nxt = {18'b0, prod};
        tovc_pkg::OP_MUL_VAL: acc_nxt = {18'b0, prod};
        tovc_pkg::OP_SHL10:   acc_nxt = {cnt_r[53:0], 10'b0};
        tovc_pkg::OP_SUB4:    acc_nxt = acc_r - {cnt_r[59:0], 4'b0};
        tovc_pkg::OP_SUB3:    acc_nxt = acc_r - {cnt_r[60:0], 3'b0};
        default:              acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cnt_r    <= ld_count;
      val_r    <= ld_value;
      act_r    <= ld_active;
      absent_r <= ld_absent;
      frq_r    <= ld_freq;
      per_r    <= ld_freq[31:16];
    end
    acc_r <= acc_nxt;
    if (advance) begin
      unique case (ctrl.cap)
        tovc_pkg::CAP_NONE: ;
        tovc_pkg::CAP_SEC: begin
          sec_r <= div_quot;
          rem_r <= div_rem[15:0];
        end
        tovc_pkg::CAP_NS1: ns_r <= div_quot[30:0];
        tovc_pkg::CAP_NS2: ns_r <= ns_r + div_quot[30:0];
        tovc_pkg::CAP_MS:  ms_r <= div_quot;
        default: ;
      endcase
    end
    if (emit) begin
      if (ctrl.zero) begin
        out_clock_active <= 1'b0;
        out_milliseconds <= '0;
        out_seconds      <= '0;
        out_nanoseconds  <= '0;
      end else begin
        out_clock_active <= act_r;
        out_milliseconds <= ms_r;
        out_seconds      <= sec_r;
        out_nanoseconds  <= ns_r;
      end
    end
  end

endmodule

// ----- rtl/timer_overflow_clock.sv -----
`timescale 1ns / 1ps

// channel   ports                                           handshake
// input     in_func, in_timer_index, in_timer_value         start high, busy low
// result    out_clock_active, out_milliseconds,             out_valid, one cycle
//           out_seconds, out_nanoseconds
// config    cfg_we, cfg_index, cfg_wdata                    cfg_we high
//
// a tick beat leaves busy low
// a read beat holds busy through four passes of the shared
// two-bit-per-cycle divider; out_valid rises as busy falls
// a read of a timer that does not exist returns zeros
// synchronous active-low reset clears all overflow counts and enable bits
// the result is shown for exactly one cycle; the receiver cannot stall

module timer_overflow_clock #(
  parameter int NUM_TIMERS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [1:0]  in_timer_index,
  input  logic [15:0] in_timer_value,
  output logic        out_valid,
  output logic        out_clock_active,
  output logic [63:0] out_milliseconds,
  output logic [63:0] out_seconds,
  output logic [30:0] out_nanoseconds,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [63:0] count_r [NUM_TIMERS];
  logic [3:0]  enabled_r;
  logic [31:0] freq_r;

  logic            accept;
  logic            exists;
  logic            active;
  logic [31:0]     idx_ext;
  logic [IW-1:0]   idx;
  logic [63:0]     sel_count;
  logic [31:0]     freq_clamped;
  tovc_pkg::ctrl_t ctrl;
  tovc_pkg::stat_t stat;
  logic            step_en;

  assign accept       = start && !busy;
  assign idx_ext      = 32'(in_timer_index);
  assign idx          = idx_ext[IW-1:0];
  assign exists       = idx_ext < 32'(NUM_TIMERS);
  assign active       = enabled_r[in_timer_index];
  assign sel_count    = exists ? count_r[idx] : '0;
  assign freq_clamped = (freq_r[31:16] == '0) ? tovc_pkg::COUNTER_SPAN : freq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        count_r[i] <= '0;
      end
      enabled_r <= '0;
      freq_r    <= tovc_pkg::FREQ_RESET;
    end else begin
      if (accept && !in_func && exists && active) begin
        count_r[idx] <= count_r[idx] + 64'd1;
      end
      if (cfg_we) begin
        unique case (tovc_pkg::reg_idx_t'(cfg_index))
          tovc_pkg::REG_ENABLED:   enabled_r <= cfg_wdata[3:0];
          tovc_pkg::REG_FREQUENCY: freq_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  tovc_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .launch     (accept && in_func),
    .stat       (stat),
    .ctrl       (ctrl),
    .step_en    (step_en),
    .busy       (busy),
    .out_strobe (out_valid)
  );

  tovc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (accept && in_func),
    .ld_count         (sel_count),
    .ld_value         (in_timer_value),
    .ld_active        (active),
    .ld_absent        (!exists),
    .ld_freq          (freq_clamped),
    .ctrl             (ctrl),
    .step_en          (step_en),
    .stat             (stat),
    .out_clock_active (out_clock_active),
    .out_milliseconds (out_milliseconds),
    .out_seconds      (out_seconds),
    .out_nanoseconds  (out_nanoseconds)
  );

endmodule
